>>> hw/rtl/swr_pkg.sv
// ----------------------------------------------------------------------------
// swr_pkg: shared types and constants of the sliding-window receiver
// Packet type codes, sequencer states and the result record.
// ----------------------------------------------------------------------------
package swr_pkg;

  localparam int SEQ_W = 32;
  localparam int CFG_W = 7;
  localparam int REL_W = 7;

  localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd8;

  // packet type codes
  localparam logic [1:0] PKT_START = 2'd0;
  localparam logic [1:0] PKT_END   = 2'd1;
  localparam logic [1:0] PKT_DATA  = 2'd2;
  localparam logic [1:0] PKT_ACK   = 2'd3;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_EXEC  = 6'b000100,
    S_RDREQ = 6'b001000,
    S_WALK  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  typedef struct packed {
    logic             ack_valid;
    logic [SEQ_W-1:0] ack_number;
    logic             file_open;
    logic [SEQ_W-1:0] file_index;
    logic             file_close;
    logic [REL_W-1:0] released_count;
  } result_t;

endpackage

>>> hw/rtl/swr_ram.sv
// ----------------------------------------------------------------------------
// swr_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module swr_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/sliding_window_receiver.sv
// ----------------------------------------------------------------------------
// sliding_window_receiver: receive side of a selective-repeat transport
// Marks in-window data packets in a ring bitmap, releases the in-order run
// and returns a cumulative ack; START/END open and close the output file.
// ----------------------------------------------------------------------------
// Flow: an accepted item is latched into the packet registers and executed in
//   S_EXEC, its result registered in res; in-window data first walks the released
//   run (S_RDREQ, S_WALK) and a START on an idle link first sweeps the bitmap.
// Throughput: one item in flight; S_DONE holds the result until the output
//   register is free, and s_tready returns the cycle after it is registered.
// Reset (rst, synchronous) clears the control state, then sweeps the bitmap RAM with s_tready low.
module sliding_window_receiver #(
  parameter int MAX_WINDOW = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sequence_number
  input  logic [2:0]  s_tuser,   // [1:0] packet_type, [2] crc_good
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [31:0] ack_number, [63:32] file_index,
                                 // [70:64] released_count, [71] zero
  output logic [2:0]  m_tuser,   // [0] ack_valid, [1] file_open, [2] file_close
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata  // window size
);

  localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int SW = $clog2(MAX_WINDOW + 1);
  localparam int WW = (SW > swr_pkg::CFG_W) ? SW : swr_pkg::CFG_W;
  localparam logic [WW-1:0] MAX_WIN   = WW'(MAX_WINDOW);
  localparam logic [AW-1:0] LAST_SLOT = AW'(MAX_WINDOW - 1);
  localparam logic [AW:0]   SLOT_WRAP = (AW + 1)'(MAX_WINDOW);
  localparam logic [SW-1:0] MAX_STEPS = SW'(MAX_WINDOW);

  swr_pkg::state_t  state;
  logic [swr_pkg::CFG_W-1:0] win_cfg;
  logic                      connected;
  logic [swr_pkg::SEQ_W-1:0] expected_seq;
  logic [AW-1:0]             exp_slot;
  logic [swr_pkg::SEQ_W-1:0] start_seq;
  logic [swr_pkg::SEQ_W-1:0] file_count;
  logic [1:0]                pkt_type;
  logic [swr_pkg::SEQ_W-1:0] pkt_seq;
  logic                      pkt_good;
  logic [SW-1:0]             steps;
  logic [AW-1:0]             clr_addr;
  logic                      clr_start;
  swr_pkg::result_t          res;
  swr_pkg::result_t          res_next;
  swr_pkg::result_t          out_data;
  logic                      out_valid;
  logic                      out_load;

  logic [WW-1:0]             win_ext;
  logic [WW-1:0]             eff_win;
  logic [swr_pkg::SEQ_W-1:0] offset;
  logic                      in_win;
  logic                      below_win;
  logic [AW:0]               slot_sum;
  logic [AW-1:0]             mark_slot;
  logic [AW-1:0]             exp_slot_inc;
  logic                      walk_go;
  logic [SW+swr_pkg::REL_W-1:0] rel_ext;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic          ram_rdata;

  // window test against the clamped window size
  assign win_ext   = WW'(win_cfg);
  assign eff_win   = (win_cfg == '0) ? WW'(1) : ((win_ext > MAX_WIN) ? MAX_WIN : win_ext);
  assign offset    = pkt_seq - expected_seq;
  assign in_win    = offset < swr_pkg::SEQ_W'(eff_win);
  assign below_win = offset[swr_pkg::SEQ_W-1];

  // slot of an in-window sequence: expected slot plus offset, one wrap at most
  assign slot_sum     = {1'b0, exp_slot} + (AW + 1)'(offset);
  assign mark_slot    = (slot_sum >= SLOT_WRAP) ? AW'(slot_sum - SLOT_WRAP) : AW'(slot_sum);
  assign exp_slot_inc = (exp_slot == LAST_SLOT) ? '0 : exp_slot + AW'(1);

  assign walk_go = ram_rdata && (steps < MAX_STEPS);
  assign rel_ext = {{swr_pkg::REL_W{1'b0}}, steps};

  assign out_load = (state == swr_pkg::S_DONE) && (!out_valid || m_tready);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = exp_slot;
    ram_wdata = 1'b0;
    ram_raddr = exp_slot;
    unique case (state)
      swr_pkg::S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
      end
      swr_pkg::S_EXEC: begin
        if (pkt_type == swr_pkg::PKT_DATA && pkt_good && in_win) begin
          ram_we    = 1'b1;
          ram_waddr = mark_slot;
          ram_wdata = 1'b1;
        end
      end
      swr_pkg::S_WALK: begin
        // clear the released mark and prefetch the following slot
        ram_we    = walk_go;
        ram_raddr = exp_slot_inc;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // result of the packet in execution, or of the finished release walk
  always_comb begin
    res_next = '0;
    if (state == swr_pkg::S_WALK) begin
      res_next.ack_valid      = 1'b1;
      res_next.ack_number     = expected_seq;
      res_next.released_count = rel_ext[swr_pkg::REL_W-1:0];
    end else if (state == swr_pkg::S_EXEC) begin
      unique case (pkt_type)
        swr_pkg::PKT_START: begin
          if (!connected) begin
            res_next.file_open  = 1'b1;
            res_next.file_index = file_count;
            res_next.ack_valid  = 1'b1;
            res_next.ack_number = pkt_seq;
          end
        end
        swr_pkg::PKT_END: begin
          res_next.file_close = connected;
          res_next.ack_valid  = 1'b1;
          res_next.ack_number = start_seq;
        end
        swr_pkg::PKT_DATA: begin
          if (pkt_good && !in_win && below_win) begin
            res_next.ack_valid  = 1'b1;
            res_next.ack_number = expected_seq;
          end
        end
        swr_pkg::PKT_ACK: ;
      endcase
    end
  end

  swr_ram #(
    .WIDTH(1),
    .DEPTH(MAX_WINDOW)
  ) u_marks (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= swr_pkg::S_CLEAR;
      win_cfg      <= swr_pkg::WINDOW_RESET;
      connected    <= 1'b0;
      expected_seq <= '0;
      exp_slot     <= '0;
      start_seq    <= '0;
      file_count   <= '0;
      clr_addr     <= '0;
      clr_start    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_we) begin
        win_cfg <= cfg_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        swr_pkg::S_CLEAR: begin
          clr_addr <= (clr_addr == LAST_SLOT) ? '0 : clr_addr + AW'(1);
          if (clr_addr == LAST_SLOT) begin
            state <= clr_start ? swr_pkg::S_DONE : swr_pkg::S_IDLE;
          end
        end
        swr_pkg::S_IDLE: begin
          if (s_tvalid) begin
            pkt_type <= s_tuser[1:0];
            pkt_good <= s_tuser[2];
            pkt_seq  <= s_tdata;
            state    <= swr_pkg::S_EXEC;
          end
        end
        swr_pkg::S_EXEC: begin
          res <= res_next;
          if (pkt_type == swr_pkg::PKT_START && !connected) begin
            connected    <= 1'b1;
            expected_seq <= '0;
            exp_slot     <= '0;
            start_seq    <= pkt_seq;
            file_count   <= file_count + swr_pkg::SEQ_W'(1);
            clr_start    <= 1'b1;
            state        <= swr_pkg::S_CLEAR;
          end else if (pkt_type == swr_pkg::PKT_DATA && pkt_good && in_win) begin
            steps <= '0;
            state <= swr_pkg::S_RDREQ;
          end else begin
            // drop START on an open link, close the link on END, pass other packets to the result
            if (pkt_type == swr_pkg::PKT_END) begin
              connected <= 1'b0;
            end
            state <= swr_pkg::S_DONE;
          end
        end
        swr_pkg::S_RDREQ: begin
          state <= swr_pkg::S_WALK;
        end
        swr_pkg::S_WALK: begin
          if (walk_go) begin
            expected_seq <= expected_seq + swr_pkg::SEQ_W'(1);
            exp_slot     <= exp_slot_inc;
            steps        <= steps + SW'(1);
          end else begin
            res   <= res_next;
            state <= swr_pkg::S_DONE;
          end
        end
        swr_pkg::S_DONE: begin
          // hold until the output register is free
          if (out_load) begin
            out_data  <= res;
            clr_start <= 1'b0;
            state     <= swr_pkg::S_IDLE;
          end
        end
      endcase
    end
  end

  assign s_tready = (state == swr_pkg::S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_data.released_count, out_data.file_index, out_data.ack_number};
  assign m_tuser  = {out_data.file_close, out_data.file_open, out_data.ack_valid};

`ifndef ASSERT_OFF
  a_accept_exec : assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == swr_pkg::S_EXEC)
    else $error("accepted transaction did not enter execution");

  a_open_acks : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tuser[0])
    else $error("file open without acknowledgement");

  a_release_acks : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[70:64] != 7'd0) |-> m_tuser[0])
    else $error("released packets without acknowledgement");

  a_steps_bound : assert property (@(posedge clk) disable iff (rst)
    state == swr_pkg::S_WALK |-> steps <= MAX_STEPS)
    else $error("release walk ran past the bitmap");
`endif

endmodule
